[rtl/core/assert_macros.svh]
// Assertion helpers for the running slerp mix unit.
// Included by the modules that check their own sequencing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by active-low reset.
`define QRSM_CHK_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, gated by active-low reset.
`define QRSM_CHK_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/qrsm_pkg.sv]
// Package for the running slerp mix unit: widths, constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package qrsm_pkg;

    localparam int COMP_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int MIX_W    = 16;
    localparam int VAL_W    = 48;
    localparam int CORDIC_W = 34;
    localparam int DIV_NW   = 45;
    localparam int DIV_DW   = 33;

    localparam logic [31:0] ONE30   = 32'h4000_0000;
    localparam logic [63:0] HALF30  = 64'h0000_0000_2000_0000;
    localparam logic [63:0] ONE60   = 64'h1000_0000_0000_0000;
    localparam logic [63:0] SQ_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] DOT_SAT = 64'h0000_0000_1000_0000;
    localparam logic [30:0] LIN_LIM = 31'h3FFF_FC00;
    localparam logic [31:0] SIN_X0  = 32'd652032874;
    localparam logic [15:0] Q_ONE   = 16'd16384;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/qrsm_in_if.sv]
// Input channel of the running slerp mix unit: one quaternion per item.
// Depends on qrsm_pkg.
`timescale 1ns / 1ps
interface qrsm_in_if import qrsm_pkg::*; #(
    parameter int COMP_BITS = COMP_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_z;
    logic signed [COMP_BITS-1:0] comp_w;
    logic                        last_item;

    modport source (output valid, comp_x, comp_y, comp_z, comp_w, last_item, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, last_item, output ready);
endinterface

[rtl/core/qrsm_out_if.sv]
// Output channel of the running slerp mix unit: one mixed unit quaternion per item.
// Depends on qrsm_pkg.
`timescale 1ns / 1ps
interface qrsm_out_if import qrsm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] mix_x;
    logic signed [MIX_W-1:0] mix_y;
    logic signed [MIX_W-1:0] mix_z;
    logic signed [MIX_W-1:0] mix_w;

    modport source (output valid, mix_x, mix_y, mix_z, mix_w, input ready);
    modport sink   (input valid, mix_x, mix_y, mix_z, mix_w, output ready);
endinterface

[rtl/core/quaternion_running_slerp_mix_unit.sv]
// Running slerp mix unit: sequencer around one multiplier, a bit-serial
// divider, a bit-serial square root and a shared CORDIC stage.
// Depends on qrsm_pkg, qrsm_in_if, qrsm_out_if and assert_macros.svh.
//
// Usage:
// i_in carries one quaternion (comp_x..comp_w, signed) and last_item per item.
// The first item of a set is normalized and kept; each later item is
// normalized, aligned in sign and slerp-blended into the running value.
// An item with last_item set yields one item on o_out (mix_x..mix_w, Q1.14)
// and clears the running value and count; other items yield nothing.
// i_in.ready is high only while the sequencer is idle: one item at a time.
// Each normalize is dominated by four quotients of the bit-serial divider
// and the square root. A later item is blended either linearly or with the
// sin weights, which take three CORDIC_STEPS runs.
// The result sits in an output register; the next item is accepted while it
// waits. A finishing item stalls only while that register is still full.
// Reset (i_rst_n low, synchronous) returns to idle with an empty set and no
// pending result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quaternion_running_slerp_mix_unit import qrsm_pkg::*; #(
    parameter int COMP_BITS    = COMP_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrsm_in_if.sink     i_in,
    qrsm_out_if.source  o_out
);

    localparam int VW = VAL_W;
    localparam int CW = CORDIC_W;
    localparam int KW = $clog2(CORDIC_STEPS);

    typedef enum logic [26:0] {
        S_IDLE    = 27'd1 << 0,
        S_N_MAX   = 27'd1 << 1,
        S_N_SHIFT = 27'd1 << 2,
        S_N_SQ    = 27'd1 << 3,
        S_N_SQA   = 27'd1 << 4,
        S_SQRT    = 27'd1 << 5,
        S_N_DIVS  = 27'd1 << 6,
        S_DIV     = 27'd1 << 7,
        S_N_DIVQ  = 27'd1 << 8,
        S_N_DONE  = 27'd1 << 9,
        S_D_MUL   = 27'd1 << 10,
        S_D_ACC   = 27'd1 << 11,
        S_D_SIGN  = 27'd1 << 12,
        S_W_DONE  = 27'd1 << 13,
        S_A_SQ    = 27'd1 << 14,
        S_A_INIT  = 27'd1 << 15,
        S_CA      = 27'd1 << 16,
        S_TH      = 27'd1 << 17,
        S_A0      = 27'd1 << 18,
        S_CS      = 27'd1 << 19,
        S_CS_DONE = 27'd1 << 20,
        S_B_MUL   = 27'd1 << 21,
        S_B_ACC0  = 27'd1 << 22,
        S_B_MUL2  = 27'd1 << 23,
        S_B_ACC1  = 27'd1 << 24,
        S_CNT     = 27'd1 << 25,
        S_FIN     = 27'd1 << 26
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;

    logic [VW-1:0]            r_m [4], n_m [4];
    logic [3:0]               r_neg, n_neg;
    logic [VW-1:0]            r_big, n_big;
    logic [1:0]               r_j, n_j;
    logic                     r_phase, n_phase, r_last, n_last;
    logic signed [63:0]       r_prod, r_acc, n_acc;
    logic [63:0]              r_sq_n, n_sq_n, r_sq_r, n_sq_r, r_bit, n_bit;
    logic [DIV_NW-1:0]        r_dnum, n_dnum;
    logic [DIV_DW-1:0]        r_den, n_den, r_rem, n_rem;
    logic [5:0]               r_dcnt, n_dcnt;
    logic signed [CW-1:0]     r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [KW-1:0]            r_k, n_k;
    logic                     r_sin2, n_sin2;
    logic signed [MIX_W-1:0]  r_qn [4], n_qn [4], r_run [4], n_run [4], r_ox [4], n_ox [4];
    logic [COUNT_BITS-1:0]    r_cnt, n_cnt;
    logic [30:0]              r_d, n_d, r_w0, n_w0;
    logic [31:0]              r_th, n_th, r_a0, n_a0;
    logic signed [31:0]       r_s0, n_s0, r_s1, n_s1;
    logic                     r_ov, n_ov;

    logic signed [COMP_BITS-1:0] in_c [4];
    logic signed [31:0]          mul_a, mul_b;
    logic signed [63:0]          mul_p;
    logic [VW-1:0]               big_c, big_01, big_23;
    logic [63:0]                 sq_t;
    logic                        sq_ge;
    logic [DIV_DW:0]             dv_t, dv_sub;
    logic                        dv_ge;
    logic signed [CW-1:0]        sh_x, sh_y, atan_v;
    logic [COUNT_BITS:0]         i1;
    logic [15:0]                 q_mag;
    logic signed [MIX_W-1:0]     q_val;
    logic [63:0]                 d_abs;
    logic signed [63:0]          b_sum, a0_sum;
    logic [VW-1:0]               v_sx;
    logic [31:0]                 th_c;
    logic                        out_load;

    assign in_c[0] = i_in.comp_x;
    assign in_c[1] = i_in.comp_y;
    assign in_c[2] = i_in.comp_z;
    assign in_c[3] = i_in.comp_w;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.mix_x = r_ox[0];
    assign o_out.mix_y = r_ox[1];
    assign o_out.mix_z = r_ox[2];
    assign o_out.mix_w = r_ox[3];

    assign big_01 = (r_m[0] > r_m[1]) ? r_m[0] : r_m[1];
    assign big_23 = (r_m[2] > r_m[3]) ? r_m[2] : r_m[3];
    assign big_c  = (big_01 > big_23) ? big_01 : big_23;

    assign sq_t  = r_sq_r + r_bit;
    assign sq_ge = (r_sq_n >= sq_t);

    assign dv_t   = {r_rem, r_dnum[DIV_NW-1]};
    assign dv_sub = dv_t - {1'b0, r_den};
    assign dv_ge  = (dv_t >= {1'b0, r_den});

    assign sh_x   = r_cx >>> r_k;
    assign sh_y   = r_cy >>> r_k;
    assign atan_v = $signed({2'b00, atan_q30(5'(r_k))});

    assign i1     = {1'b0, r_cnt} + (COUNT_BITS+1)'(1);
    assign q_mag  = (r_dnum > DIV_NW'(Q_ONE)) ? Q_ONE : r_dnum[15:0];
    assign q_val  = r_neg[r_j] ? -$signed(q_mag) : $signed(q_mag);
    assign d_abs  = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign b_sum  = r_acc + r_prod;
    assign a0_sum = r_prod + $signed(HALF30);
    assign th_c   = r_cz[CW-1] ? 32'd0 : r_cz[31:0];
    assign out_load = (r_state == S_FIN) && (!r_ov || o_out.ready);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_N_SQ: begin
                mul_a = $signed({2'b00, r_m[r_j][29:0]});
                mul_b = $signed({2'b00, r_m[r_j][29:0]});
            end
            S_D_MUL: begin
                mul_a = 32'(r_run[r_j]);
                mul_b = 32'(r_qn[r_j]);
            end
            S_W_DONE: begin
                mul_a = $signed({1'b0, r_d});
                mul_b = $signed({1'b0, r_d});
            end
            S_TH: begin
                mul_a = $signed({1'b0, r_w0});
                mul_b = $signed(th_c);
            end
            S_B_MUL: begin
                mul_a = r_s0;
                mul_b = 32'(r_run[r_j]);
            end
            S_B_MUL2: begin
                mul_a = r_s1;
                mul_b = 32'(r_qn[r_j]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_m     = r_m;
        n_neg   = r_neg;
        n_big   = r_big;
        n_j     = r_j;
        n_phase = r_phase;
        n_last  = r_last;
        n_acc   = r_acc;
        n_sq_n  = r_sq_n;
        n_sq_r  = r_sq_r;
        n_bit   = r_bit;
        n_dnum  = r_dnum;
        n_den   = r_den;
        n_rem   = r_rem;
        n_dcnt  = r_dcnt;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cz    = r_cz;
        n_k     = r_k;
        n_sin2  = r_sin2;
        n_qn    = r_qn;
        n_run   = r_run;
        n_ox    = r_ox;
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_w0    = r_w0;
        n_th    = r_th;
        n_a0    = r_a0;
        n_s0    = r_s0;
        n_s1    = r_s1;
        n_ov    = r_ov && !o_out.ready;
        v_sx    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    for (int i = 0; i < 4; i++) begin
                        v_sx     = VW'(in_c[i]);
                        n_neg[i] = in_c[i][COMP_BITS-1];
                        n_m[i]   = in_c[i][COMP_BITS-1] ? (VW'(0) - v_sx) : v_sx;
                    end
                    n_last  = i_in.last_item;
                    n_phase = 1'b0;
                    n_state = S_N_MAX;
                end
            end
            S_N_MAX: begin
                if (big_c == '0) begin
                    for (int i = 0; i < 4; i++) begin
                        if (r_phase) begin
                            n_run[i] = '0;
                        end else begin
                            n_qn[i] = '0;
                        end
                    end
                    n_state = S_N_DONE;
                end else begin
                    n_big   = big_c;
                    n_state = S_N_SHIFT;
                end
            end
            S_N_SHIFT: begin
                if (r_big[VW-1:30] != '0) begin
                    for (int i = 0; i < 4; i++) n_m[i] = r_m[i] >> 1;
                    n_big = r_big >> 1;
                end else if (!r_big[29]) begin
                    for (int i = 0; i < 4; i++) n_m[i] = r_m[i] << 1;
                    n_big = r_big << 1;
                end else begin
                    n_j     = '0;
                    n_acc   = '0;
                    n_state = S_N_SQ;
                end
            end
            S_N_SQ: begin
                n_state = S_N_SQA;
            end
            S_N_SQA: begin
                n_acc = r_acc + r_prod;
                n_j   = r_j + 2'd1;
                if (r_j == 2'd3) begin
                    n_sq_n  = 64'(r_acc + r_prod);
                    n_sq_r  = '0;
                    n_bit   = SQ_BIT0;
                    n_ret   = S_N_DIVS;
                    n_state = S_SQRT;
                end else begin
                    n_state = S_N_SQ;
                end
            end
            S_SQRT: begin
                if (sq_ge) begin
                    n_sq_n = r_sq_n - sq_t;
                    n_sq_r = (r_sq_r >> 1) + r_bit;
                end else begin
                    n_sq_r = r_sq_r >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = r_ret;
                end
            end
            S_N_DIVS: begin
                n_dnum  = DIV_NW'({r_m[r_j][29:0], 14'b0}) + DIV_NW'(r_sq_r[31:1]);
                n_den   = DIV_DW'(r_sq_r[31:0]);
                n_rem   = '0;
                n_dcnt  = '0;
                n_ret   = S_N_DIVQ;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = dv_ge ? dv_sub[DIV_DW-1:0] : dv_t[DIV_DW-1:0];
                n_dnum = {r_dnum[DIV_NW-2:0], dv_ge};
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'(DIV_NW-1)) begin
                    n_state = r_ret;
                end
            end
            S_N_DIVQ: begin
                if (r_phase) begin
                    n_run[r_j] = q_val;
                end else begin
                    n_qn[r_j] = q_val;
                end
                n_j     = r_j + 2'd1;
                n_state = (r_j == 2'd3) ? S_N_DONE : S_N_DIVS;
            end
            S_N_DONE: begin
                if (r_phase) begin
                    n_state = S_CNT;
                end else if (r_cnt == '0) begin
                    n_run   = r_qn;
                    n_state = S_CNT;
                end else begin
                    n_acc   = '0;
                    n_j     = '0;
                    n_state = S_D_MUL;
                end
            end
            S_D_MUL: begin
                n_state = S_D_ACC;
            end
            S_D_ACC: begin
                n_acc   = r_acc + r_prod;
                n_j     = r_j + 2'd1;
                n_state = (r_j == 2'd3) ? S_D_SIGN : S_D_MUL;
            end
            S_D_SIGN: begin
                if (r_acc[63]) begin
                    for (int i = 0; i < 4; i++) n_qn[i] = -r_qn[i];
                end
                n_d     = (d_abs >= DOT_SAT) ? ONE30[30:0] : {d_abs[28:0], 2'b00};
                n_dnum  = DIV_NW'(ONE30) + DIV_NW'(i1 >> 1);
                n_den   = DIV_DW'(i1);
                n_rem   = '0;
                n_dcnt  = '0;
                n_ret   = S_W_DONE;
                n_state = S_DIV;
            end
            S_W_DONE: begin
                n_w0 = r_dnum[30:0];
                if (r_d >= LIN_LIM) begin
                    n_s0    = $signed({1'b0, r_dnum[30:0]});
                    n_s1    = $signed(ONE30 - {1'b0, r_dnum[30:0]});
                    n_j     = '0;
                    n_state = S_B_MUL;
                end else begin
                    n_state = S_A_SQ;
                end
            end
            S_A_SQ: begin
                n_sq_n  = ONE60 - 64'(r_prod);
                n_sq_r  = '0;
                n_bit   = SQ_BIT0;
                n_ret   = S_A_INIT;
                n_state = S_SQRT;
            end
            S_A_INIT: begin
                n_cx    = $signed({3'b000, r_d});
                n_cy    = $signed({2'b00, r_sq_r[31:0]});
                n_cz    = '0;
                n_k     = '0;
                n_state = S_CA;
            end
            S_CA: begin
                if (r_cy > 0) begin
                    n_cx = r_cx + sh_y;
                    n_cy = r_cy - sh_x;
                    n_cz = r_cz + atan_v;
                end else begin
                    n_cx = r_cx - sh_y;
                    n_cy = r_cy + sh_x;
                    n_cz = r_cz - atan_v;
                end
                n_k = r_k + KW'(1);
                if (r_k == KW'(CORDIC_STEPS-1)) begin
                    n_state = S_TH;
                end
            end
            S_TH: begin
                n_th    = th_c;
                n_state = S_A0;
            end
            S_A0: begin
                n_a0    = a0_sum[61:30];
                n_cx    = $signed({2'b00, SIN_X0});
                n_cy    = '0;
                n_cz    = $signed({2'b00, a0_sum[61:30]});
                n_k     = '0;
                n_sin2  = 1'b0;
                n_state = S_CS;
            end
            S_CS: begin
                if (!r_cz[CW-1]) begin
                    n_cx = r_cx - sh_y;
                    n_cy = r_cy + sh_x;
                    n_cz = r_cz - atan_v;
                end else begin
                    n_cx = r_cx + sh_y;
                    n_cy = r_cy - sh_x;
                    n_cz = r_cz + atan_v;
                end
                n_k = r_k + KW'(1);
                if (r_k == KW'(CORDIC_STEPS-1)) begin
                    n_state = S_CS_DONE;
                end
            end
            S_CS_DONE: begin
                if (!r_sin2) begin
                    n_s0    = r_cy[31:0];
                    n_cx    = $signed({2'b00, SIN_X0});
                    n_cy    = '0;
                    n_cz    = $signed({2'b00, r_th - r_a0});
                    n_k     = '0;
                    n_sin2  = 1'b1;
                    n_state = S_CS;
                end else begin
                    n_s1    = r_cy[31:0];
                    n_j     = '0;
                    n_state = S_B_MUL;
                end
            end
            S_B_MUL: begin
                n_state = S_B_ACC0;
            end
            S_B_ACC0: begin
                n_acc   = r_prod;
                n_state = S_B_MUL2;
            end
            S_B_MUL2: begin
                n_state = S_B_ACC1;
            end
            S_B_ACC1: begin
                n_neg[r_j] = b_sum[63];
                n_m[r_j]   = b_sum[63] ? VW'(-b_sum) : VW'(b_sum);
                n_j        = r_j + 2'd1;
                if (r_j == 2'd3) begin
                    n_phase = 1'b1;
                    n_state = S_N_MAX;
                end else begin
                    n_state = S_B_MUL;
                end
            end
            S_CNT: begin
                if (r_last) begin
                    n_state = S_FIN;
                end else begin
                    if (!(&r_cnt)) begin
                        n_cnt = r_cnt + COUNT_BITS'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_ox = r_run;
                    n_ov = 1'b1;
                    for (int i = 0; i < 4; i++) n_run[i] = '0;
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < 4; i++) r_run[i] <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_run   <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_p;
        r_m     <= n_m;
        r_neg   <= n_neg;
        r_big   <= n_big;
        r_j     <= n_j;
        r_phase <= n_phase;
        r_last  <= n_last;
        r_acc   <= n_acc;
        r_sq_n  <= n_sq_n;
        r_sq_r  <= n_sq_r;
        r_bit   <= n_bit;
        r_dnum  <= n_dnum;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_k     <= n_k;
        r_sin2  <= n_sin2;
        r_qn    <= n_qn;
        r_ox    <= n_ox;
        r_d     <= n_d;
        r_w0    <= n_w0;
        r_th    <= n_th;
        r_a0    <= n_a0;
        r_s0    <= n_s0;
        r_s1    <= n_s1;
    end

    `QRSM_CHK_IMP(a_div_den_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_den != '0)
    `QRSM_CHK_IMP(a_sqrt_bit_live, i_clk, i_rst_n, r_state == S_SQRT, r_bit != '0)
    `QRSM_CHK_IMP(a_mix_in_range, i_clk, i_rst_n, r_ov, (r_ox[0] >= -16'sd16384) && (r_ox[0] <= 16'sd16384) && (r_ox[3] >= -16'sd16384) && (r_ox[3] <= 16'sd16384))
    `QRSM_CHK_NXT(a_fin_clears_set, i_clk, i_rst_n, out_load, (r_cnt == '0) && r_ov && (r_state == S_IDLE))

endmodule
